/* hdl/srec_pkg.sv */
`default_nettype none

package srec_pkg;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_TYPE,
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_SUM
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_TERM = 2'd1,
        ST_ERR  = 2'd2,
        ST_RESV = 2'd3
    } status_t;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [3:0] TYPE_RESV  = 4'd4;
    localparam logic [3:0] TYPE_TERM  = 4'd7;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [31:0] byte_address;
        logic [3:0] record_type;
        status_t    status;
    } result_t;

    // Bit 4 set marks a character that is not an upper-case hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [3:0] d;
        begin
            d = 4'd0;
            if (c >= CHAR_0 && c <= CHAR_9)
            begin
                d = 4'(c - CHAR_0);
                hex_value = {1'b0, d};
            end
            else if (c >= CHAR_A && c <= CHAR_F)
            begin
                d = 4'(c - CHAR_A + 8'd10);
                hex_value = {1'b0, d};
            end
            else
            begin
                hex_value = 5'h10;
            end
        end
    endfunction

    function automatic logic [2:0] addr_size(input logic [3:0] t);
        begin
            case (t)
                4'd2, 4'd6, 4'd8: addr_size = 3'd3;
                4'd3, 4'd7:       addr_size = 3'd4;
                default:          addr_size = 3'd2;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/srecord_line_parser.sv */
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata[7:0] = character
// m_        out        m_tvalid/m_tready  m_tdata = data_byte, byte_address,
//                                         record_type, status; m_tuser = kind
//
// One character is taken in every cycle while s_tready is high; its result,
// if any, goes to the output register, or to the second result register
// while the output is stalled. The decode is a single state update from the
// accepted character to the parser registers and a result register. The
// second one absorbs one result; s_tready falls only while it is full.
// rst_n clears the parser to the wait-for-'S' state and empties both registers.

module srecord_line_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] character
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] data_byte, [39:8] byte_address,
                                        // [43:40] record_type, [45:44] status
    output logic [0:0]       m_tuser    // [0] kind
);

    srec_pkg::phase_t  phase_reg, phase_next;
    logic [3:0]        rec_type_reg, rec_type_next;
    logic [7:0]        bytes_left_reg, bytes_left_next;
    logic [2:0]        addr_left_reg, addr_left_next;
    logic [31:0]       address_reg, address_next;
    logic [7:0]        offset_reg, offset_next;
    logic [7:0]        sum_reg, sum_next;
    logic [3:0]        high_nib_reg, high_nib_next;
    logic              pending_reg, pending_next;

    srec_pkg::result_t out_reg, skid_reg, res;
    logic              out_valid_reg, skid_valid_reg;
    logic              res_valid;

    logic              accept, pop;
    logic [4:0]        hv;
    logic [7:0]        b;
    logic [2:0]        asize;
    logic [7:0]        need;
    logic [3:0]        type_digit;

    assign accept = s_tvalid && s_tready;
    assign pop    = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;

    assign hv         = srec_pkg::hex_value(s_tdata);
    assign b          = {high_nib_reg, hv[3:0]};
    assign asize      = srec_pkg::addr_size(rec_type_reg);
    assign need       = {5'd0, asize} + 8'd1;
    assign type_digit = s_tdata[3:0];

    always_comb
    begin
        phase_next     = phase_reg;
        rec_type_next  = rec_type_reg;
        bytes_left_next = bytes_left_reg;
        addr_left_next = addr_left_reg;
        address_next   = address_reg;
        offset_next    = offset_reg;
        sum_next       = sum_reg;
        high_nib_next  = high_nib_reg;
        pending_next   = pending_reg;

        res_valid        = 1'b0;
        res.kind         = srec_pkg::KIND_END;
        res.data_byte    = 8'd0;
        res.byte_address = address_reg;
        res.record_type  = rec_type_reg;
        res.status       = srec_pkg::ST_ERR;

        if (phase_reg == srec_pkg::PH_WAIT)
        begin
            if (s_tdata == srec_pkg::CHAR_S)
            begin
                phase_next      = srec_pkg::PH_TYPE;
                rec_type_next   = 4'd0;
                bytes_left_next = 8'd0;
                addr_left_next  = 3'd0;
                address_next    = 32'd0;
                offset_next     = 8'd0;
                sum_next        = 8'd0;
                high_nib_next   = 4'd0;
                pending_next    = 1'b0;
            end
        end
        else if (s_tdata == srec_pkg::CHAR_S)
        begin
            // A new record starts inside the current one: report the broken one.
            res_valid       = 1'b1;
            phase_next      = srec_pkg::PH_TYPE;
            rec_type_next   = 4'd0;
            bytes_left_next = 8'd0;
            addr_left_next  = 3'd0;
            address_next    = 32'd0;
            offset_next     = 8'd0;
            sum_next        = 8'd0;
            high_nib_next   = 4'd0;
            pending_next    = 1'b0;
        end
        else if (phase_reg == srec_pkg::PH_TYPE)
        begin
            if (s_tdata >= srec_pkg::CHAR_0 && s_tdata <= srec_pkg::CHAR_9)
            begin
                rec_type_next = type_digit;
                if (type_digit == srec_pkg::TYPE_RESV)
                begin
                    phase_next      = srec_pkg::PH_WAIT;
                    res_valid       = 1'b1;
                    res.record_type = type_digit;
                    res.status      = srec_pkg::ST_RESV;
                end
                else
                begin
                    phase_next = srec_pkg::PH_COUNT;
                end
            end
            else
            begin
                phase_next = srec_pkg::PH_WAIT;
                res_valid  = 1'b1;
            end
        end
        else if (hv[4])
        begin
            phase_next = srec_pkg::PH_WAIT;
            res_valid  = 1'b1;
        end
        else if (!pending_reg)
        begin
            high_nib_next = hv[3:0];
            pending_next  = 1'b1;
        end
        else
        begin
            pending_next = 1'b0;
            case (phase_reg)
                srec_pkg::PH_COUNT:
                begin
                    sum_next = b;
                    if (b < need)
                    begin
                        phase_next = srec_pkg::PH_WAIT;
                        res_valid  = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = b - need;
                        addr_left_next  = asize;
                        phase_next      = srec_pkg::PH_ADDR;
                    end
                end
                srec_pkg::PH_ADDR:
                begin
                    address_next   = {address_reg[23:0], b};
                    sum_next       = sum_reg + b;
                    addr_left_next = addr_left_reg - 3'd1;
                    if (addr_left_next == 3'd0)
                    begin
                        phase_next = (bytes_left_reg != 8'd0) ? srec_pkg::PH_DATA
                                                              : srec_pkg::PH_SUM;
                    end
                end
                srec_pkg::PH_DATA:
                begin
                    sum_next         = sum_reg + b;
                    res_valid        = 1'b1;
                    res.kind         = srec_pkg::KIND_DATA;
                    res.data_byte    = b;
                    res.byte_address = address_reg + {24'd0, offset_reg};
                    res.status       = srec_pkg::ST_OK;
                    offset_next      = offset_reg + 8'd1;
                    bytes_left_next  = bytes_left_reg - 8'd1;
                    if (bytes_left_next == 8'd0)
                    begin
                        phase_next = srec_pkg::PH_SUM;
                    end
                end
                srec_pkg::PH_SUM:
                begin
                    phase_next = srec_pkg::PH_WAIT;
                    res_valid  = 1'b1;
                    if (~sum_reg != b)
                    begin
                        res.status = srec_pkg::ST_ERR;
                    end
                    else if (rec_type_reg >= srec_pkg::TYPE_TERM)
                    begin
                        res.status = srec_pkg::ST_TERM;
                    end
                    else
                    begin
                        res.status = srec_pkg::ST_OK;
                    end
                end
                default:
                begin
                    phase_next = srec_pkg::PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= srec_pkg::PH_WAIT;
            rec_type_reg   <= 4'd0;
            bytes_left_reg <= 8'd0;
            addr_left_reg  <= 3'd0;
            address_reg    <= 32'd0;
            offset_reg     <= 8'd0;
            sum_reg        <= 8'd0;
            high_nib_reg   <= 4'd0;
            pending_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            rec_type_reg   <= rec_type_next;
            bytes_left_reg <= bytes_left_next;
            addr_left_reg  <= addr_left_next;
            address_reg    <= address_next;
            offset_reg     <= offset_next;
            sum_reg        <= sum_next;
            high_nib_reg   <= high_nib_next;
            pending_reg    <= pending_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && res_valid)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; the valid flags above decide which copy is live.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept && res_valid)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.status, out_reg.record_type,
                       out_reg.byte_address, out_reg.data_byte};
    assign m_tuser  = out_reg.kind;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srec_pkg::*;

    typedef struct {
        logic [7:0] ch;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] character
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // [7:0] data_byte, [39:8] byte_address,
                                    // [43:40] record_type, [45:44] status
    logic [0:0]  m_tuser;           // [0] kind

    srecord_line_parser i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Shadow copy of the parser registers.
    phase_t      ph = PH_WAIT;
    logic [3:0]  cur_type = '0;
    logic [7:0]  bytes_left = '0;
    logic [2:0]  addr_left = '0;
    logic [31:0] rec_addr = '0;
    logic [7:0]  byte_offs = '0;
    logic [7:0]  csum = '0;
    logic [3:0]  hi_nib = '0;
    bit          nib_pend = 1'b0;

    result_t     pending_results[$];
    int unsigned mismatches = 0;
    int unsigned parsed_chars = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;
    bit          hold_req = 1'b0;

    function automatic int unsigned addr_len(input logic [3:0] t);
        if (t == 4'd2 || t == 4'd6 || t == 4'd8)
        begin
            return 3;
        end
        if (t == 4'd3 || t == 4'd7)
        begin
            return 4;
        end
        return 2;
    endfunction

    function automatic void open_record();
        ph = PH_TYPE;
        cur_type = '0;
        bytes_left = '0;
        addr_left = '0;
        rec_addr = '0;
        byte_offs = '0;
        csum = '0;
        hi_nib = '0;
        nib_pend = 1'b0;
    endfunction

    function automatic result_t end_result(input status_t s);
        result_t r;
        r = '0;
        r.kind = KIND_END;
        r.byte_address = rec_addr;
        r.record_type = cur_type;
        r.status = s;
        return r;
    endfunction

    // Advances the shadow parser by one character; returns 1 when a result is due.
    function automatic bit decode_char(input logic [7:0] c, output result_t r);
        logic [4:0] v;
        logic [7:0] b;
        int unsigned need;
        r = '0;
        if (ph == PH_WAIT)
        begin
            if (c == CHAR_S)
            begin
                open_record();
            end
            return 1'b0;
        end
        if (c == CHAR_S)
        begin
            r = end_result(ST_ERR);
            open_record();
            return 1'b1;
        end
        if (ph == PH_TYPE)
        begin
            if (c >= CHAR_0 && c <= CHAR_9)
            begin
                cur_type = 4'(c - CHAR_0);
                if (cur_type == TYPE_RESV)
                begin
                    ph = PH_WAIT;
                    r = end_result(ST_RESV);
                    return 1'b1;
                end
                ph = PH_COUNT;
                return 1'b0;
            end
            ph = PH_WAIT;
            r = end_result(ST_ERR);
            return 1'b1;
        end
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            v = 5'(c - CHAR_0);
        end
        else if (c >= CHAR_A && c <= CHAR_F)
        begin
            v = 5'(c - CHAR_A + 8'd10);
        end
        else
        begin
            ph = PH_WAIT;
            r = end_result(ST_ERR);
            return 1'b1;
        end
        if (!nib_pend)
        begin
            hi_nib = v[3:0];
            nib_pend = 1'b1;
            return 1'b0;
        end
        nib_pend = 1'b0;
        b = {hi_nib, v[3:0]};
        case (ph)
            PH_COUNT:
            begin
                csum = b;
                need = addr_len(cur_type) + 1;
                if (b < need)
                begin
                    ph = PH_WAIT;
                    r = end_result(ST_ERR);
                    return 1'b1;
                end
                bytes_left = 8'(b - need);
                addr_left = 3'(addr_len(cur_type));
                ph = PH_ADDR;
                return 1'b0;
            end
            PH_ADDR:
            begin
                rec_addr = {rec_addr[23:0], b};
                csum = csum + b;
                addr_left = addr_left - 3'd1;
                if (addr_left == 3'd0)
                begin
                    ph = (bytes_left != 8'd0) ? PH_DATA : PH_SUM;
                end
                return 1'b0;
            end
            PH_DATA:
            begin
                csum = csum + b;
                r.kind = KIND_DATA;
                r.data_byte = b;
                r.byte_address = rec_addr + {24'd0, byte_offs};
                r.record_type = cur_type;
                r.status = ST_OK;
                byte_offs = byte_offs + 8'd1;
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0)
                begin
                    ph = PH_SUM;
                end
                return 1'b1;
            end
            PH_SUM:
            begin
                ph = PH_WAIT;
                if (~csum != b)
                begin
                    r = end_result(ST_ERR);
                end
                else
                begin
                    r = end_result(cur_type >= TYPE_TERM ? ST_TERM : ST_OK);
                end
                return 1'b1;
            end
            default:
            begin
                ph = PH_WAIT;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic stim_row_t plain_row(input logic [7:0] c);
        stim_row_t row;
        row.ch = c;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic stim_row_t end_row(input logic [7:0] c, input logic [31:0] a,
                                          input logic [3:0] t, input status_t s);
        stim_row_t row;
        row.ch = c;
        row.typed = 1'b1;
        row.want = '0;
        row.want.kind = KIND_END;
        row.want.byte_address = a;
        row.want.record_type = t;
        row.want.status = s;
        return row;
    endfunction

    function automatic void push_hex(ref logic [7:0] q[$], input logic [7:0] v);
        logic [3:0] n;
        for (int k = 1; k >= 0; k--)
        begin
            n = v[4*k +: 4];
            q.push_back(n < 4'd10 ? CHAR_0 + 8'(n) : CHAR_A + 8'(n) - 8'd10);
        end
    endfunction

    // Offers one character, waits for its transaction and records what it should cause.
    task automatic send_char(input logic [7:0] c, input bit typed, input result_t want);
        result_t pr;
        bit      has;
        while (src_idle_en && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        parsed_chars++;
        has = decode_char(c, pr);
        if (typed)
        begin
            pending_results.push_back(want);
        end
        else if (has)
        begin
            pending_results.push_back(pr);
        end
    endtask

    task automatic send_record();
        logic [7:0]  q[$];
        logic [31:0] a;
        logic [7:0]  b;
        logic [7:0]  sum;
        int unsigned t;
        int unsigned alen;
        int unsigned nd;
        int unsigned cnt;
        int unsigned pick;
        int unsigned cut;
        q.push_back(CHAR_S);
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            q.push_back(8'($urandom_range(0, 255)));
            t = 0;
        end
        else
        begin
            t = $urandom_range(0, 9);
            q.push_back(CHAR_0 + 8'(t));
        end
        alen = addr_len(4'(t));
        pick = $urandom_range(0, 999);
        if (pick < 12)
        begin
            nd = $urandom_range(0, 255 - (alen + 1));
        end
        else if (pick < 130)
        begin
            nd = $urandom_range(9, 40);
        end
        else
        begin
            nd = $urandom_range(0, 8);
        end
        cnt = alen + 1 + nd;
        if ($urandom_range(0, 99) < 4)
        begin
            cnt = $urandom_range(0, alen);
        end
        push_hex(q, 8'(cnt));
        sum = 8'(cnt);
        a = $urandom();
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            a = '0;
        end
        else if (pick == 1)
        begin
            a = '1;
        end
        for (int i = alen; i > 0; i--)
        begin
            b = a[8*i-1 -: 8];
            push_hex(q, b);
            sum = sum + b;
        end
        for (int i = 0; i < nd; i++)
        begin
            b = 8'($urandom_range(0, 255));
            push_hex(q, b);
            sum = sum + b;
        end
        b = ~sum;
        if ($urandom_range(0, 99) < 10)
        begin
            b = b ^ 8'($urandom_range(1, 255));
        end
        push_hex(q, b);
        // Occasionally damage the record: a stray character or a truncated tail.
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            q[$urandom_range(1, q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else if (pick < 9)
        begin
            cut = $urandom_range(1, q.size() - 1);
            while (q.size() > cut)
            begin
                void'(q.pop_back());
            end
        end
        pick = $urandom_range(0, 3);
        for (int i = 0; i < pick; i++)
        begin
            if ($urandom_range(0, 99) < 60)
            begin
                q.push_back(8'h0D);
                q.push_back(8'h0A);
            end
            else
            begin
                q.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (q[i])
        begin
            send_char(q[i], 1'b0, '0);
        end
    endtask

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("srecord_line_parser verification failed");
        $finish;
    end

    // Receiver: checks each result transaction and chooses the next tready.
    initial
    begin
        result_t     got;
        result_t     want;
        int unsigned hold_left;
        bit          rdy;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.kind = m_tuser[0];
                got.data_byte = m_tdata[7:0];
                got.byte_address = m_tdata[39:8];
                got.record_type = m_tdata[43:40];
                got.status = status_t'(m_tdata[45:44]);
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result: kind %0d byte %h addr %h type %0d status %0d",
                                 got.kind, got.data_byte, got.byte_address,
                                 got.record_type, got.status);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: expected kind %0d byte %h addr %h type %0d status %0d",
                                     want.kind, want.data_byte, want.byte_address,
                                     want.record_type, want.status);
                            $display("          actual   kind %0d byte %h addr %h type %0d status %0d",
                                     got.kind, got.data_byte, got.byte_address,
                                     got.record_type, got.status);
                        end
                    end
                end
            end
            if (hold_req)
            begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                rdy = !(sink_idle_en && $urandom_range(0, 99) < 31);
            end
            m_tready <= rdy;
        end
    end

    initial
    begin
        stim_row_t   dir_tab[$];
        int unsigned rec_no;

        dir_tab.push_back(plain_row(8'h00));
        dir_tab.push_back(plain_row(8'hFF));
        // Reserved type ends the record at once.
        dir_tab.push_back(plain_row(CHAR_S));
        dir_tab.push_back(end_row("4", 32'h0, 4'd4, ST_RESV));
        // Type character that is not a digit.
        dir_tab.push_back(plain_row(CHAR_S));
        dir_tab.push_back(end_row("X", 32'h0, 4'd0, ST_ERR));
        // Count too small for the address.
        dir_tab.push_back(plain_row(CHAR_S));
        dir_tab.push_back(plain_row("1"));
        dir_tab.push_back(plain_row("0"));
        dir_tab.push_back(end_row("2", 32'h0, 4'd1, ST_ERR));
        // Lower-case letters are not hex digits here.
        dir_tab.push_back(plain_row(CHAR_S));
        dir_tab.push_back(plain_row("9"));
        dir_tab.push_back(end_row("g", 32'h0, 4'd9, ST_ERR));
        // An S inside a record breaks it and opens the next one.
        dir_tab.push_back(plain_row(CHAR_S));
        dir_tab.push_back(plain_row("3"));
        dir_tab.push_back(end_row(CHAR_S, 32'h0, 4'd3, ST_ERR));
        // S1, count 04, address FFFF, one data byte FF, wrong checksum 00.
        dir_tab.push_back(plain_row("1"));
        dir_tab.push_back(plain_row("0"));
        dir_tab.push_back(plain_row("4"));
        for (int i = 0; i < 6; i++)
        begin
            dir_tab.push_back(plain_row("F"));
        end
        dir_tab.push_back(plain_row("0"));
        dir_tab.push_back(end_row("0", 32'h0000FFFF, 4'd1, ST_ERR));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            send_char(dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].want);
        end

        parsed_chars = 0;
        rec_no = 0;
        hold_req = 1'b1;
        while (parsed_chars < 1750)
        begin
            src_idle_en = !(rec_no >= 30 && rec_no < 45);
            sink_idle_en = src_idle_en;
            if (rec_no == 55)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            send_record();
            rec_no++;
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("srecord_line_parser verification clean");
        end
        else
        begin
            $display("srecord_line_parser verification failed");
        end
        $finish;
    end

endmodule
